/* hw/rtl/cftab_pkg.sv */
// ----------------------------------------------------------------------------
// cftab_pkg
// Shared types, widths and constants of the CAN frame id table.
// ----------------------------------------------------------------------------
package cftab_pkg;

    // Table size and derived widths
    localparam int ENTRIES = 64;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int ID_W       = 11;
    localparam int DATA_W     = 32;
    localparam int HITS_W     = 32;
    localparam int OUT_SLOT_W = 6;

    // Stream widths (fields packed from bit 0 up, padded to bytes)
    localparam int IN_FIELDS_W  = ID_W + 3 * DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = OUT_SLOT_W + 3 + HITS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // ISO 15765-2 service byte selection
    localparam logic [DATA_W-1:0] FIRST_FRAME_SERVICE_MASK = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] OTHER_SERVICE_MASK       = 32'h00FF_FF00;
    localparam logic [7:0]        FRAME_TYPE_MASK          = 8'hF0;
    localparam logic [7:0]        FRAME_TYPE_FIRST         = 8'h10;

    // Search token walking down the cell row
    typedef struct packed {
        logic                vld;
        logic [SLOT_W-1:0]   pos;
        logic [ID_W-1:0]     id;
        logic [DATA_W-1:0]   lo;
        logic [DATA_W-1:0]   hi;
        logic [DATA_W-1:0]   ts;
        logic                done;
        logic                matched;
        logic                changed;
        logic [HITS_W-1:0]   hits;
        logic [SLOT_W-1:0]   slot;
    } token_t;

    // One result item
    typedef struct packed {
        logic                    dropped;
        logic [HITS_W-1:0]       hit_total;
        logic                    data_changed;
        logic                    matched;
        logic [OUT_SLOT_W-1:0]   slot;
    } result_t;

    // Service bytes to compare, chosen by the frame type nibble of byte 0
    function automatic logic [DATA_W-1:0] svc_mask(input logic [DATA_W-1:0] lo);
        logic [DATA_W-1:0] mask;
        if ((lo[7:0] & FRAME_TYPE_MASK) == FRAME_TYPE_FIRST)
        begin
            mask = FIRST_FRAME_SERVICE_MASK;
        end
        else
        begin
            mask = OTHER_SERVICE_MASK;
        end
        return mask;
    endfunction

endpackage

/* hw/rtl/cftab_cell.sv */
// ----------------------------------------------------------------------------
// cftab_cell
// One table entry: compares the passing token, updates or creates the entry,
// and hands the token to the next cell.
// ----------------------------------------------------------------------------
module cftab_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       diag_mode,
    input  logic [cftab_pkg::CNT_W-1:0] entry_count,
    input  cftab_pkg::token_t          tok_in,
    output cftab_pkg::token_t          tok_out
);
    import cftab_pkg::*;

    logic [ID_W-1:0]   id_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] time_reg;
    logic [HITS_W-1:0] hits_reg;
    token_t            tok_reg;
    token_t            tok_next;

    logic              live;
    logic              svc_ok;
    logic              hit;
    logic              create;
    logic              changed;
    logic [HITS_W-1:0] hits_inc;
    logic [DATA_W-1:0] mask;

    // Match and append decisions
    always_comb
    begin
        mask     = svc_mask(tok_in.lo);
        live     = CNT_W'(tok_in.pos) < entry_count;
        svc_ok   = !diag_mode || ((lo_reg & mask) == (tok_in.lo & mask));
        hit      = tok_in.vld && !tok_in.done && live && (id_reg == tok_in.id) && svc_ok;
        create   = tok_in.vld && !tok_in.done && (CNT_W'(tok_in.pos) == entry_count);
        changed  = (lo_reg != tok_in.lo) || (hi_reg != tok_in.hi);
        hits_inc = (hits_reg == '1) ? hits_reg : hits_reg + HITS_W'(1);
    end

    // Token to the neighbor
    always_comb
    begin
        tok_next     = tok_in;
        tok_next.pos = tok_in.pos + SLOT_W'(1);
        if (hit)
        begin
            tok_next.done    = 1'b1;
            tok_next.matched = 1'b1;
            tok_next.changed = changed;
            tok_next.hits    = hits_inc;
            tok_next.slot    = tok_in.pos;
        end
        else if (create)
        begin
            tok_next.done    = 1'b1;
            tok_next.matched = 1'b0;
            tok_next.changed = 1'b0;
            tok_next.hits    = '0;
            tok_next.slot    = tok_in.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            lo_reg   <= tok_in.lo;
            hi_reg   <= tok_in.hi;
            hits_reg <= hits_inc;
            if (changed)
            begin
                time_reg <= tok_in.ts;
            end
        end
        else if (create)
        begin
            id_reg   <= tok_in.id;
            lo_reg   <= tok_in.lo;
            hi_reg   <= tok_in.hi;
            time_reg <= tok_in.ts;
            hits_reg <= '0;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hw/rtl/cftab_out_buf.sv */
// ----------------------------------------------------------------------------
// cftab_out_buf
// Output register with one skid entry for result transfers.
// ----------------------------------------------------------------------------
module cftab_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  cftab_pkg::result_t  in_item,
    output logic                out_vld,
    input  logic                out_ready,
    output cftab_pkg::result_t  out_item,
    output logic                skid_full
);
    import cftab_pkg::*;

    logic    out_vld_reg;
    logic    skid_vld_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    free;

    assign free = !out_vld_reg || out_ready;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (free)
        begin
            out_vld_reg  <= skid_vld_reg || in_vld;
            skid_vld_reg <= skid_vld_reg && in_vld;
        end
        else if (in_vld)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (free)
        begin
            if (skid_vld_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= in_item;
            end
            else
            begin
                out_reg <= in_item;
            end
        end
        else if (in_vld)
        begin
            skid_reg <= in_item;
        end
    end

    assign out_vld   = out_vld_reg;
    assign out_item  = out_reg;
    assign skid_full = skid_vld_reg;

endmodule

/* hw/rtl/can_frame_id_table_unit.sv */
// ----------------------------------------------------------------------------
// can_frame_id_table_unit
// Table of distinct received CAN frames, searched by a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received frame (id, two data words, timestamp). A
//   search token enters the first cell and moves one cell per cycle; each
//   cell holds one table entry. The first live entry that matches (on id, and
//   in diagnostic mode also on the service bytes) is updated; otherwise the
//   first empty cell takes the frame as a new entry. A token that leaves the
//   last cell unclaimed means the table is full and the frame is dropped.
//   m_axis returns one result per frame, in order.
//   The token is registered in every cell, then the result in the output
//   register before m_axis_tvalid. One frame is in the row at a time, so a
//   new frame is taken only after the previous one has left the row. A
//   stalled receiver does not hold the row: a result waits in the output
//   register and one more in a skid entry; input is refused while a frame
//   is in the row and while the skid entry is full. The user must write
//   cfg_data (diag_mode) only while idle; the block does not enforce it.
//   Reset empties the table (entry count zero) and clears diag_mode.
// ----------------------------------------------------------------------------
module can_frame_id_table_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // frame_id[10:0], data_low[42:11], data_high[74:43], timestamp[106:75]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [cftab_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // slot[5:0], matched[6], data_changed[7], hit_total[39:8], dropped[40]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cftab_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data
);
    import cftab_pkg::*;

    logic             diag_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             in_xfer;
    logic             skid_full;
    token_t           head_tok;
    token_t           chain [0:ENTRIES];
    token_t           exit_tok;
    result_t          res;
    result_t          out_item;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg && !skid_full;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Token injected at the head of the row
    always_comb
    begin
        head_tok         = '0;
        head_tok.vld     = in_xfer;
        head_tok.id      = s_axis_tdata[ID_W-1:0];
        head_tok.lo      = s_axis_tdata[ID_W +: DATA_W];
        head_tok.hi      = s_axis_tdata[ID_W + DATA_W +: DATA_W];
        head_tok.ts      = s_axis_tdata[ID_W + 2*DATA_W +: DATA_W];
    end

    assign chain[0] = head_tok;

    // Cell row
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        cftab_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .diag_mode   (diag_reg),
            .entry_count (count_reg),
            .tok_in      (chain[k]),
            .tok_out     (chain[k+1])
        );
    end

    assign exit_tok = chain[ENTRIES];

    // Result from the token leaving the row
    always_comb
    begin
        res              = '0;
        res.dropped      = !exit_tok.done;
        if (exit_tok.done)
        begin
            res.slot         = OUT_SLOT_W'(exit_tok.slot);
            res.matched      = exit_tok.matched;
            res.data_changed = exit_tok.changed;
            res.hit_total    = exit_tok.hits;
        end
    end

    // Control: config, busy flag, entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                diag_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                busy_reg <= 1'b1;
            end
            else if (exit_tok.vld)
            begin
                busy_reg <= 1'b0;
            end
            if (exit_tok.vld && exit_tok.done && !exit_tok.matched)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    cftab_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (exit_tok.vld),
        .in_item   (res),
        .out_vld   (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item),
        .skid_full (skid_full)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_item};

    // Checks
    a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok.vld |-> busy_reg)
        else $error("token left the row with no frame in flight");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (exit_tok.vld && !exit_tok.done) |-> (count_reg == CNT_W'(ENTRIES)))
        else $error("frame dropped while table not full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    a_skid_room: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok.vld |-> !skid_full)
        else $error("result arrived with skid entry occupied");

    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> busy_reg)
        else $error("busy not set after input transfer");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN frame id table unit. A directed table
// covers field extremes, plain and service-byte matching, data changes and
// first-frame service byte selection. Random traffic then replays table
// entries, sends pool ids and new ids, and fills the table until frames drop.
// Every result is checked against an in-bench model of the table, with
// random stalls on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cftab_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 2 * (ENTRIES + 1) + 20;
    localparam int DIR_ROWS    = 17;

    // One received frame, frame_id in the low bits
    typedef struct packed {
        logic [DATA_W-1:0] ts;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic [ID_W-1:0]   id;
    } frame_t;

    typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e         kind;
        bit                cfg_val;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] ts;
        bit                typed;
        logic [5:0]        e_slot;
        bit                e_matched;
        bit                e_changed;
        logic [31:0]       e_hits;
        bit                e_dropped;
    } dir_row_t;

    // Hand-written result for one frame, or none
    typedef struct {
        bit      typed;
        result_t res;
    } known_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_data;

    // Table model state
    logic [ID_W-1:0]   seen_id   [ENTRIES];
    logic [DATA_W-1:0] seen_lo   [ENTRIES];
    logic [DATA_W-1:0] seen_hi   [ENTRIES];
    logic [HITS_W-1:0] seen_hits [ENTRIES];
    int unsigned       seen_count;
    bit                svc_match;

    result_t       pending_results [$];
    known_result_t typed_results [$];
    dir_row_t      dir_rows [DIR_ROWS];
    logic [ID_W-1:0] id_pool [16];

    int unsigned err_count;
    int unsigned quiet_cycles;
    int unsigned n_frames, n_new, n_update, n_changed, n_drop, n_cfg;
    bit          hold_req;
    bit          hold_active;

    can_frame_id_table_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Search the table for a frame, update or append, and return the result
    function automatic result_t table_update(frame_t f);
        result_t           res;
        logic [DATA_W-1:0] mask;
        bit                hit;
        int unsigned       k;
        int unsigned       at;
        res  = '0;
        hit  = 1'b0;
        at   = 0;
        mask = ((f.lo[7:0] & FRAME_TYPE_MASK) == FRAME_TYPE_FIRST) ?
               FIRST_FRAME_SERVICE_MASK : OTHER_SERVICE_MASK;
        for (k = 0; k < seen_count && !hit; k++)
        begin
            if (seen_id[k] == f.id && (!svc_match || (seen_lo[k] & mask) == (f.lo & mask)))
            begin
                hit = 1'b1;
                at  = k;
            end
        end
        if (hit)
        begin
            res.matched      = 1'b1;
            res.data_changed = (seen_lo[at] != f.lo) || (seen_hi[at] != f.hi);
            seen_lo[at] = f.lo;
            seen_hi[at] = f.hi;
            if (seen_hits[at] != '1)
            begin
                seen_hits[at] = seen_hits[at] + 1;
            end
            res.hit_total = seen_hits[at];
            res.slot      = OUT_SLOT_W'(at);
        end
        else if (seen_count < ENTRIES)
        begin
            seen_id[seen_count]   = f.id;
            seen_lo[seen_count]   = f.lo;
            seen_hi[seen_count]   = f.hi;
            seen_hits[seen_count] = '0;
            res.slot   = OUT_SLOT_W'(seen_count);
            seen_count = seen_count + 1;
        end
        else
        begin
            res.dropped = 1'b1;
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Random frame: mostly replays of table entries, some pool ids, some new ids
    function automatic frame_t make_frame();
        frame_t      f;
        int unsigned r;
        int unsigned k;
        f.id = ID_W'($urandom);
        f.lo = $urandom;
        f.hi = $urandom;
        f.ts = $urandom;
        r    = $urandom_range(0, 99);
        if (seen_count != 0 && r < 35)
        begin
            // exact repeat of an entry's data
            k    = $urandom_range(0, seen_count - 1);
            f.id = seen_id[k];
            f.lo = seen_lo[k];
            f.hi = seen_hi[k];
        end
        else if (seen_count != 0 && r < 65)
        begin
            // same id, frame type and service bytes, new payload
            k    = $urandom_range(0, seen_count - 1);
            f.id = seen_id[k];
            f.lo[31:4] = seen_lo[k][31:4];
        end
        else
        begin
            if (r < 90)
            begin
                f.id = id_pool[$urandom_range(0, 15)];
            end
            if ($urandom_range(0, 9) < 3)
            begin
                f.lo[7:4] = 4'h1;
            end
        end
        if ($urandom_range(0, 31) == 0)
        begin
            f.ts = $urandom_range(0, 1) ? '1 : '0;
        end
        return f;
    endfunction

    // Model update on input transfers, result checks on output transfers
    always @(posedge clk)
    begin
        frame_t        f;
        result_t       pred;
        result_t       got;
        result_t       want;
        known_result_t kr;
        if (rst_n)
        begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready)
            begin
                svc_match = cfg_data;
                n_cfg++;
                quiet_cycles = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                f    = frame_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
                pred = table_update(f);
                kr.typed = 1'b0;
                kr.res   = '0;
                if (typed_results.size() != 0)
                begin
                    kr = typed_results.pop_front();
                end
                pending_results.insert(pending_results.size(), kr.typed ? kr.res : pred);
                n_frames++;
                quiet_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
                quiet_cycles = 0;
                if (pending_results.size() == 0)
                begin
                    $error("result with no frame pending: 0x%0h", got);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("slot", 32'(want.slot), 32'(got.slot));
                    check_field("matched", 32'(want.matched), 32'(got.matched));
                    check_field("data_changed", 32'(want.data_changed), 32'(got.data_changed));
                    check_field("hit_total", want.hit_total, got.hit_total);
                    check_field("dropped", 32'(want.dropped), 32'(got.dropped));
                end
                n_new     += (!got.matched && !got.dropped);
                n_update  += got.matched;
                n_changed += got.data_changed;
                n_drop    += got.dropped;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: random ready pattern, with one long hold-off on request
    initial
    begin
        int unsigned r;
        int unsigned n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req      = 1'b0;
                hold_active   = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active   = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(1, 20);
                end
                else if (r < 80)
                begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(1, 3);
                end
                else if (r < 92)
                begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(10, 100);
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(150, 300);
                end
                repeat (n) @(negedge clk);
            end
        end
    end

    // Offer one frame after a gap; returns at the falling edge after the transfer
    task automatic drive_frame(input frame_t f, input int unsigned gap, input known_result_t kr);
        typed_results.insert(typed_results.size(), kr);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(f);
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Write diag_mode once the table has answered every frame
    task automatic write_mode(input bit v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 || typed_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input bit squeeze);
        frame_t        f;
        known_result_t kr;
        int unsigned   gap;
        int unsigned   r;
        kr.typed = 1'b0;
        kr.res   = '0;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (squeeze && i == 3)
            begin
                hold_req = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (hold_active || r < 70)
            begin
                gap = 0;
            end
            else if (r < 92)
            begin
                gap = $urandom_range(1, 4);
            end
            else
            begin
                gap = $urandom_range(10, 80);
            end
            f = make_frame();
            drive_frame(f, gap, kr);
        end
    endtask

    // Stimulus
    initial
    begin
        frame_t        f;
        known_result_t kr;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        rst_n         = 1'b0;
        svc_match     = 1'b0;
        seen_count    = 0;
        err_count     = 0;
        quiet_cycles  = 0;
        hold_req      = 1'b0;
        hold_active   = 1'b0;
        n_frames = 0; n_new = 0; n_update = 0; n_changed = 0; n_drop = 0; n_cfg = 0;

        // kind, cfg, id, data_low, data_high, timestamp,
        // typed, slot, matched, changed, hits, dropped
        dir_rows = '{
            // empty table: field extremes become new entries
            '{ROW_FRAME, 0, 11'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              1, 0, 0, 0, 0, 0},
            '{ROW_FRAME, 0, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1, 1, 0, 0, 0, 0},
            // repeat with same data, then with new data
            '{ROW_FRAME, 0, 11'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0005,
              1, 0, 1, 0, 1, 0},
            '{ROW_FRAME, 0, 11'h000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0006,
              1, 0, 1, 1, 2, 0},
            '{ROW_FRAME, 0, 11'h7FF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0007,
              1, 1, 1, 1, 1, 0},
            '{ROW_FRAME, 0, 11'h123, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'h8000_0000,
              1, 2, 0, 0, 0, 0},
            // service bytes take part in the match
            '{ROW_CFG, 1, 11'h000, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0},
            '{ROW_FRAME, 0, 11'h000, 32'h00AB_CD00, 32'h0000_0000, 32'h0000_0010,
              1, 3, 0, 0, 0, 0},
            '{ROW_FRAME, 0, 11'h000, 32'h11AB_CD00, 32'h0000_0000, 32'h0000_0011,
              1, 3, 1, 1, 1, 0},
            // first frames compare the upper half of data_low
            '{ROW_FRAME, 0, 11'h000, 32'h2222_1010, 32'h0000_0000, 32'h0000_0012,
              1, 4, 0, 0, 0, 0},
            '{ROW_FRAME, 0, 11'h000, 32'h2222_5513, 32'h0000_0000, 32'h0000_0013,
              1, 4, 1, 1, 1, 0},
            '{ROW_FRAME, 0, 11'h000, 32'h2222_5513, 32'h0000_0000, 32'h0000_0014,
              1, 4, 1, 0, 2, 0},
            '{ROW_FRAME, 0, 11'h000, 32'h2222_5520, 32'h0000_0000, 32'h0000_0015,
              0, 0, 0, 0, 0, 0},
            '{ROW_FRAME, 0, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
              0, 0, 0, 0, 0, 0},
            // back to id-only matching: lowest slot wins
            '{ROW_CFG, 0, 11'h000, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0},
            '{ROW_FRAME, 0, 11'h000, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0016,
              1, 0, 1, 1, 3, 0},
            '{ROW_FRAME, 0, 11'h2AA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_AAAA,
              0, 0, 0, 0, 0, 0}
        };
        foreach (id_pool[i])
        begin
            id_pool[i] = ID_W'($urandom_range(0, 2047));
        end

        // Reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_mode(1'b0);

        // Directed rows
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                write_mode(dir_rows[i].cfg_val);
            end
            else
            begin
                f.id = dir_rows[i].id;
                f.lo = dir_rows[i].lo;
                f.hi = dir_rows[i].hi;
                f.ts = dir_rows[i].ts;
                kr.typed            = dir_rows[i].typed;
                kr.res.slot         = dir_rows[i].e_slot;
                kr.res.matched      = dir_rows[i].e_matched;
                kr.res.data_changed = dir_rows[i].e_changed;
                kr.res.hit_total    = dir_rows[i].e_hits;
                kr.res.dropped      = dir_rows[i].e_dropped;
                drive_frame(f, $urandom_range(0, 3), kr);
            end
        end

        // Random traffic: id-only, then service-byte matching, then id-only
        run_random(280, 1'b0);
        write_mode(1'b1);
        run_random(280, 1'b1);
        write_mode(1'b0);
        run_random(290, 1'b0);

        // Drain
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            err_count++;
        end

        $display("Run covered %0d frames: %0d new entries, %0d updates",
                 n_frames, n_new, n_update);
        $display("(%0d with new data), %0d drops, table ended with %0d entries, %0d mode writes",
                 n_changed, n_drop, seen_count, n_cfg);
        if (err_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cftab_pkg.sv
hw/rtl/cftab_cell.sv
hw/rtl/cftab_out_buf.sv
hw/rtl/can_frame_id_table_unit.sv
sim/tb_top.sv
